### rtl/button_press_classifier_unit_defines.svh
// Assertion macros for the button press classifier.
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define BPC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define BPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define BPC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### rtl/bpc_pkg.sv
package bpc_pkg;

    typedef enum logic [2:0] {
        EV_SHORT      = 3'd0,
        EV_RELEASED   = 3'd1,
        EV_LONG       = 3'd2,
        EV_VERY_LONG  = 3'd3,
        EV_RESET_HOLD = 3'd4
    } event_code_t;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;
    localparam int TimeWidth     = 32;

    localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_MIN_PRESS  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_SHORT_MAX  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_LONG       = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_VERY_LONG  = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_RESET_HOLD = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_COOLDOWN   = 3'd6;

    localparam logic [CfgDataWidth-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CfgDataWidth-1:0] MIN_PRESS_RST  = 16'd50;
    localparam logic [CfgDataWidth-1:0] SHORT_MAX_RST  = 16'd1000;
    localparam logic [CfgDataWidth-1:0] LONG_RST       = 16'd4000;
    localparam logic [CfgDataWidth-1:0] VERY_LONG_RST  = 16'd7000;
    localparam logic [CfgDataWidth-1:0] RESET_HOLD_RST = 16'd10000;
    localparam logic [CfgDataWidth-1:0] COOLDOWN_RST   = 16'd500;

    localparam logic [2:0] TIER_LONG      = 3'b001;
    localparam logic [2:0] TIER_VERY_LONG = 3'b010;
    localparam logic [2:0] TIER_RESET     = 3'b100;

endpackage

### rtl/button_press_classifier_unit.sv
// Pipeline: an accepted sample waits in the input register until processed; its result is
// then registered in the result register. Throughput: one sample per cycle while the output
// is not stalled and the sample yields at most one result; a sample that yields a short press
// and a release holds the input while the second result leaves through the pending register.
// Reset: synchronous, active low; clears all press state and loads register defaults.
`include "button_press_classifier_unit_defines.svh"

module button_press_classifier_unit
    import bpc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_pin_level,
    input  logic [TimeWidth-1:0]     s_now_ms,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_event_code,
    output logic [TimeWidth-1:0]     m_duration_ms,
    output logic                     m_last_event,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    logic [CfgDataWidth-1:0] debounce_reg, min_press_reg, short_max_reg, long_reg;
    logic [CfgDataWidth-1:0] very_long_reg, reset_hold_reg, cooldown_reg;

    logic                 in_valid_reg;
    logic                 in_level_reg;
    logic [TimeWidth-1:0] in_now_reg;

    logic                 prev_level_reg, stable_level_reg, pressing_reg;
    logic [TimeWidth-1:0] change_time_reg, press_start_reg, valid_press_reg;
    logic [2:0]           tier_reg;

    logic                 m_valid_reg, m_last_reg, pend_valid_reg;
    event_code_t          m_code_reg;
    logic [TimeWidth-1:0] m_dur_reg, pend_dur_reg;

    logic                 proc;
    logic                 stable_level_next, pressing_next;
    logic [TimeWidth-1:0] change_time_next, press_start_next, valid_press_next;
    logic [2:0]           tier_next;
    logic [TimeWidth-1:0] since_change, dur, since_valid, hold;
    logic                 take_level, rel_fire, press_ok, short_fire;
    logic [2:0]           tier_bit;
    event_code_t          tier_code;
    logic                 tier_fire;
    logic [1:0]           res_cnt;
    event_code_t          r0_code;
    logic [TimeWidth-1:0] r0_dur;

    assign proc      = in_valid_reg && !pend_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;

    always_comb begin
        change_time_next  = (in_level_reg != prev_level_reg) ? in_now_reg : change_time_reg;
        since_change      = in_now_reg - change_time_next;
        take_level        = (since_change > {16'd0, debounce_reg})
                            && (in_level_reg != stable_level_reg);
        stable_level_next = take_level ? in_level_reg : stable_level_reg;
        press_start_next  = press_start_reg;
        pressing_next     = pressing_reg;
        valid_press_next  = valid_press_reg;
        dur               = in_now_reg - press_start_reg;
        since_valid       = in_now_reg - valid_press_reg;
        rel_fire          = take_level && in_level_reg && pressing_reg;
        press_ok          = (dur > {16'd0, min_press_reg})
                            && (since_valid > {16'd0, cooldown_reg});
        short_fire        = rel_fire && press_ok && (dur < {16'd0, short_max_reg});
        if (take_level && !in_level_reg) begin
            press_start_next = in_now_reg;
            pressing_next    = 1'b1;
        end
        if (rel_fire) begin
            pressing_next = 1'b0;
            if (press_ok) begin
                valid_press_next = in_now_reg;
            end
        end
    end

    always_comb begin
        hold = in_now_reg - press_start_next;
        if (hold >= {16'd0, reset_hold_reg}) begin
            tier_bit  = TIER_RESET;
            tier_code = EV_RESET_HOLD;
        end else if (hold >= {16'd0, very_long_reg}) begin
            tier_bit  = TIER_VERY_LONG;
            tier_code = EV_VERY_LONG;
        end else if (hold >= {16'd0, long_reg}) begin
            tier_bit  = TIER_LONG;
            tier_code = EV_LONG;
        end else begin
            tier_bit  = 3'b000;
            tier_code = EV_LONG;
        end
        tier_fire = pressing_next && ((tier_bit & ~tier_reg) != 3'b000);
        tier_next = pressing_next ? (tier_reg | tier_bit) : 3'b000;
    end

    always_comb begin
        if (rel_fire) begin
            res_cnt = short_fire ? 2'd2 : 2'd1;
            r0_code = short_fire ? EV_SHORT : EV_RELEASED;
            r0_dur  = dur;
        end else if (tier_fire) begin
            res_cnt = 2'd1;
            r0_code = tier_code;
            r0_dur  = hold;
        end else begin
            res_cnt = 2'd0;
            r0_code = EV_RELEASED;
            r0_dur  = dur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RST;
            min_press_reg  <= MIN_PRESS_RST;
            short_max_reg  <= SHORT_MAX_RST;
            long_reg       <= LONG_RST;
            very_long_reg  <= VERY_LONG_RST;
            reset_hold_reg <= RESET_HOLD_RST;
            cooldown_reg   <= COOLDOWN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_MIN_PRESS:  min_press_reg  <= cfg_data;
                REG_SHORT_MAX:  short_max_reg  <= cfg_data;
                REG_LONG:       long_reg       <= cfg_data;
                REG_VERY_LONG:  very_long_reg  <= cfg_data;
                REG_RESET_HOLD: reset_hold_reg <= cfg_data;
                REG_COOLDOWN:   cooldown_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_pin_level;
            in_now_reg   <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg   <= 1'b1;
            stable_level_reg <= 1'b1;
            change_time_reg  <= '0;
            press_start_reg  <= '0;
            valid_press_reg  <= '0;
            pressing_reg     <= 1'b0;
            tier_reg         <= 3'b000;
        end else if (proc) begin
            prev_level_reg   <= in_level_reg;
            stable_level_reg <= stable_level_next;
            change_time_reg  <= change_time_next;
            press_start_reg  <= press_start_next;
            valid_press_reg  <= valid_press_next;
            pressing_reg     <= pressing_next;
            tier_reg         <= tier_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (proc && (res_cnt != 2'd0)) begin
            m_valid_reg    <= 1'b1;
            pend_valid_reg <= (res_cnt == 2'd2);
        end else if (m_valid_reg && m_ready) begin
            m_valid_reg    <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && (res_cnt != 2'd0)) begin
            m_code_reg   <= r0_code;
            m_dur_reg    <= r0_dur;
            m_last_reg   <= (res_cnt == 2'd1);
            pend_dur_reg <= dur;
        end else if (m_valid_reg && m_ready && pend_valid_reg) begin
            m_code_reg <= EV_RELEASED;
            m_dur_reg  <= pend_dur_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_code  = m_code_reg;
    assign m_duration_ms = m_dur_reg;
    assign m_last_event  = m_last_reg;

    `BPC_ASSERT_SAME(a_pend_behind_out, aclk, aresetn, pend_valid_reg, m_valid_reg)
    `BPC_ASSERT_SAME(a_pend_after_short, aclk, aresetn, pend_valid_reg,
                     m_code_reg == EV_SHORT && !m_last_reg)
    `BPC_ASSERT_NEXT(a_two_results_queue, aclk, aresetn, proc && res_cnt == 2'd2,
                     pend_valid_reg && m_valid_reg)
    `BPC_ASSERT_SAME(a_tiers_clear_idle, aclk, aresetn, !pressing_reg, tier_reg == 3'b000)

endmodule

### tb/tb_button_press_classifier_unit.sv
module tb_button_press_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int CycleLimit = 400000;

    typedef struct {
        event_code_t      code;
        logic [31:0]      dur;
        logic             last;
    } press_event_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_pin_level = 1'b1;
    logic [TimeWidth-1:0]     s_now_ms = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [2:0]               m_event_code;
    logic [TimeWidth-1:0]     m_duration_ms;
    logic                     m_last_event;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_data = '0;

    // classifier state mirrored on the bench side
    logic [15:0] cfg_regs [0:6];
    logic        lvl_prev;
    logic        lvl_stable;
    logic [31:0] edge_ms;
    logic [31:0] press_ms;
    logic [31:0] valid_rel_ms;
    logic        held;
    logic [2:0]  tiers_done;

    press_event_t queued_events[$];

    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_off_left = 0;
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          beats_seen = 0;
    int          reg_writes = 0;
    int          cycle_count = 0;
    logic [31:0] sample_ms = '0;

    button_press_classifier_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pin_level   (s_pin_level),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_code  (m_event_code),
        .m_duration_ms (m_duration_ms),
        .m_last_event  (m_last_event),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5ns aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, queued_events.size());
            $display("tb_button_press_classifier_unit failed");
            $finish;
        end
    end

    // output side: random stall, or a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    always @(posedge aclk) begin
        press_event_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (queued_events.size() == 0) begin
                report_mismatch($sformatf("unexpected beat code %0d dur %0d last %0b",
                                          m_event_code, m_duration_ms, m_last_event));
            end else begin
                want = queued_events.pop_front();
                if (m_event_code !== want.code) begin
                    report_mismatch($sformatf("event_code %0d, want %0d",
                                              m_event_code, want.code));
                end
                if (m_duration_ms !== want.dur) begin
                    report_mismatch($sformatf("duration_ms %0d, want %0d",
                                              m_duration_ms, want.dur));
                end
                if (m_last_event !== want.last) begin
                    report_mismatch($sformatf("last_event %0b, want %0b",
                                              m_last_event, want.last));
                end
            end
        end
    end

    task automatic reset_predictor();
        cfg_regs[REG_DEBOUNCE]   = DEBOUNCE_RST;
        cfg_regs[REG_MIN_PRESS]  = MIN_PRESS_RST;
        cfg_regs[REG_SHORT_MAX]  = SHORT_MAX_RST;
        cfg_regs[REG_LONG]       = LONG_RST;
        cfg_regs[REG_VERY_LONG]  = VERY_LONG_RST;
        cfg_regs[REG_RESET_HOLD] = RESET_HOLD_RST;
        cfg_regs[REG_COOLDOWN]   = COOLDOWN_RST;
        lvl_prev     = 1'b1;
        lvl_stable   = 1'b1;
        edge_ms      = '0;
        press_ms     = '0;
        valid_rel_ms = '0;
        held         = 1'b0;
        tiers_done   = '0;
    endtask

    task automatic classify_sample(input logic level, input logic [31:0] now);
        press_event_t evs[$];
        logic [31:0]  dur;
        logic [31:0]  hold;
        logic [2:0]   tier_bit;
        event_code_t  tier_code;
        if (level != lvl_prev) begin
            edge_ms = now;
        end
        if ((now - edge_ms) > 32'(cfg_regs[REG_DEBOUNCE]) && level != lvl_stable) begin
            lvl_stable = level;
            if (level == 1'b0) begin
                press_ms = now;
                held     = 1'b1;
            end else if (held) begin
                dur  = now - press_ms;
                held = 1'b0;
                if (dur > 32'(cfg_regs[REG_MIN_PRESS]) &&
                    (now - valid_rel_ms) > 32'(cfg_regs[REG_COOLDOWN])) begin
                    valid_rel_ms = now;
                    if (dur < 32'(cfg_regs[REG_SHORT_MAX])) begin
                        evs.push_back('{EV_SHORT, dur, 1'b0});
                    end
                end
                evs.push_back('{EV_RELEASED, dur, 1'b0});
            end
        end
        if (held) begin
            hold      = now - press_ms;
            tier_bit  = '0;
            tier_code = EV_LONG;
            if (hold >= 32'(cfg_regs[REG_RESET_HOLD])) begin
                tier_bit  = TIER_RESET;
                tier_code = EV_RESET_HOLD;
            end else if (hold >= 32'(cfg_regs[REG_VERY_LONG])) begin
                tier_bit  = TIER_VERY_LONG;
                tier_code = EV_VERY_LONG;
            end else if (hold >= 32'(cfg_regs[REG_LONG])) begin
                tier_bit  = TIER_LONG;
                tier_code = EV_LONG;
            end
            if (tier_bit != '0 && (tiers_done & tier_bit) == '0) begin
                evs.push_back('{tier_code, hold, 1'b0});
                tiers_done = tiers_done | tier_bit;
            end
        end else begin
            tiers_done = '0;
        end
        lvl_prev = level;
        if (evs.size() > 0) begin
            evs[evs.size() - 1].last = 1'b1;
        end
        foreach (evs[i]) begin
            queued_events.push_back(evs[i]);
        end
    endtask

    task automatic send_sample(input logic level, input logic [31:0] now);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_pin_level <= level;
        s_now_ms    <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        classify_sample(level, now);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] val);
        @(negedge aclk);
        s_valid   <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx <= REG_COOLDOWN) begin
            cfg_regs[idx] = val;
        end
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic [15:0] deb, input logic [15:0] min_press,
                               input logic [15:0] short_max, input logic [15:0] long_hold,
                               input logic [15:0] very_long_hold,
                               input logic [15:0] reset_hold, input logic [15:0] cool);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_MIN_PRESS, min_press);
        write_reg(REG_SHORT_MAX, short_max);
        write_reg(REG_LONG, long_hold);
        write_reg(REG_VERY_LONG, very_long_hold);
        write_reg(REG_RESET_HOLD, reset_hold);
        write_reg(REG_COOLDOWN, cool);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (queued_events.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [31:0] later_of(input logic [31:0] a, input logic [31:0] b);
        return ($signed(a - b) >= 0) ? a : b;
    endfunction

    function automatic logic [31:0] near_ms(input logic [31:0] base);
        return base + 32'($urandom_range(0, 2)) - 32'd1;
    endfunction

    function automatic logic [31:0] jitter_ms();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'($urandom_range(0, 3));
            4, 5, 6:    return 32'($urandom_range(0, 2 * cfg_regs[REG_DEBOUNCE] + 2));
            7, 8:       return 32'($urandom_range(0, 200000));
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] hold_target_ms();
        case ($urandom_range(0, 3))
            0:       return near_ms(32'(cfg_regs[REG_LONG]));
            1:       return near_ms(32'(cfg_regs[REG_VERY_LONG]));
            2:       return near_ms(32'(cfg_regs[REG_RESET_HOLD]));
            default: return 32'($urandom_range(0, 140000));
        endcase
    endfunction

    function automatic logic [31:0] release_target_ms();
        case ($urandom_range(0, 4))
            0:       return near_ms(32'(cfg_regs[REG_MIN_PRESS]));
            1:       return near_ms(32'(cfg_regs[REG_SHORT_MAX]));
            2:       return near_ms(valid_rel_ms + 32'(cfg_regs[REG_COOLDOWN])) - press_ms;
            3:       return 32'($urandom_range(0, 2 * cfg_regs[REG_SHORT_MAX] + 64));
            default: return hold_target_ms();
        endcase
    endfunction

    // mostly whole bounce-press-hold-release cycles, some raw noise
    task automatic send_press_cycles(input int n_items);
        int          stop_at;
        logic [31:0] target;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 12) begin
                sample_ms = sample_ms + jitter_ms();
                send_sample(1'($urandom_range(0, 1)), sample_ms);
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    sample_ms = sample_ms + 32'($urandom_range(0, 3));
                    send_sample(~lvl_prev, sample_ms);
                end
                if (lvl_prev != 1'b0) begin
                    sample_ms = sample_ms + 32'($urandom_range(0, 3));
                    send_sample(1'b0, sample_ms);
                end
                target    = edge_ms + 32'(cfg_regs[REG_DEBOUNCE]) + 32'($urandom_range(0, 2));
                sample_ms = later_of(target, sample_ms);
                send_sample(1'b0, sample_ms);
                repeat ($urandom_range(0, 3)) begin
                    sample_ms = later_of(press_ms + hold_target_ms(),
                                         sample_ms + 32'($urandom_range(0, 2)));
                    send_sample(1'b0, sample_ms);
                end
                repeat ($urandom_range(0, 2)) begin
                    sample_ms = sample_ms + 32'($urandom_range(0, 3));
                    send_sample(~lvl_prev, sample_ms);
                end
                if (lvl_prev != 1'b1) begin
                    sample_ms = sample_ms + 32'($urandom_range(0, 3));
                    send_sample(1'b1, sample_ms);
                end
                target = later_of(press_ms + release_target_ms(),
                                  edge_ms + 32'(cfg_regs[REG_DEBOUNCE]) +
                                  32'($urandom_range(0, 2)));
                sample_ms = later_of(target, sample_ms);
                send_sample(1'b1, sample_ms);
                repeat ($urandom_range(0, 2)) begin
                    sample_ms = sample_ms + jitter_ms();
                    send_sample(1'b1, sample_ms);
                end
            end
        end
    endtask

    task automatic test_directed_defaults();
        send_sample(1'b1, 32'd1000);
        send_sample(1'b0, 32'd1000);
        send_sample(1'b1, 32'd1005);
        send_sample(1'b0, 32'd1010);
        send_sample(1'b0, 32'd1060);
        send_sample(1'b0, 32'd1061);
        send_sample(1'b1, 32'd1300);
        send_sample(1'b1, 32'd1351);
        send_sample(1'b0, 32'd1400);
        send_sample(1'b0, 32'd1451);
        send_sample(1'b1, 32'd1500);
        send_sample(1'b1, 32'd1551);
        send_sample(1'b0, 32'd3000);
        send_sample(1'b0, 32'd3051);
        send_sample(1'b0, 32'd7050);
        send_sample(1'b0, 32'd7051);
        send_sample(1'b0, 32'd10051);
        send_sample(1'b0, 32'd13051);
        send_sample(1'b0, 32'd20000);
        send_sample(1'b1, 32'd20001);
        send_sample(1'b1, 32'd20052);
        send_sample(1'b0, 32'd30000);
        send_sample(1'b0, 32'd30051);
        send_sample(1'b1, 32'd31000);
        send_sample(1'b1, 32'd31051);
        wait_drained();
    endtask

    task automatic test_zero_thresholds();
        load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        write_reg(3'd7, 16'hFFFF);
        send_sample(1'b0, 32'hFFFF_FFFE);
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_0000);
        send_sample(1'b1, 32'h0000_0001);
        wait_drained();
    endtask

    task automatic test_backpressure();
        load_config(16'd3, 16'd8, 16'd40, 16'd60, 16'd90, 16'd120, 16'd25);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        sample_ms          = 32'd5000;
        @(posedge aclk);
        hold_off_left = 400;
        send_press_cycles(60);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        sample_ms = $urandom();
        load_config(DEBOUNCE_RST, MIN_PRESS_RST, SHORT_MAX_RST, LONG_RST,
                    VERY_LONG_RST, RESET_HOLD_RST, COOLDOWN_RST);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_press_cycles(250);
        wait_drained();

        load_config(16'd3, 16'd8, 16'd40, 16'd60, 16'd90, 16'd120, 16'd25);
        sender_idle_pct    = 55;
        receiver_stall_pct = 0;
        send_press_cycles(300);
        wait_drained();

        // tiers out of order: reset hold lowest, long highest
        load_config(16'd2, 16'd5, 16'd30, 16'd150, 16'd100, 16'd50, 16'd10);
        sender_idle_pct    = 0;
        receiver_stall_pct = 55;
        send_press_cycles(300);
        wait_drained();

        load_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                    16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                    16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                    16'($urandom_range(0, 300)));
        sender_idle_pct    = 38;
        receiver_stall_pct = 38;
        sample_ms          = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
        send_press_cycles(300);
        wait_drained();

        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_press_cycles(150);
        wait_drained();

        load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        sender_idle_pct    = 55;
        receiver_stall_pct = 0;
        sample_ms          = $urandom();
        send_press_cycles(150);
        wait_drained();

        load_config(DEBOUNCE_RST, MIN_PRESS_RST, SHORT_MAX_RST, LONG_RST,
                    VERY_LONG_RST, RESET_HOLD_RST, COOLDOWN_RST);
        sender_idle_pct    = 0;
        receiver_stall_pct = 55;
        send_press_cycles(200);
        wait_drained();
    endtask

    initial begin
        reset_predictor();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(negedge aclk);

        test_directed_defaults();
        test_zero_thresholds();
        test_backpressure();
        test_random_traffic();

        $display("covered %0d samples, %0d result beats, %0d register writes",
                 items_sent, beats_seen, reg_writes);
        $display({"configs: defaults, all zero, all max, unordered and random tiers; ",
                  "pacing with idle, stall and a long output hold-off"});
        if (mismatch_count == 0) begin
            $display("tb_button_press_classifier_unit passed");
        end else begin
            $display("tb_button_press_classifier_unit failed");
        end
        $finish;
    end

endmodule
